// ===== rtl/iqws_pkg.sv =====
package iqws_pkg;

   // field widths fixed by the interface
   localparam int OP_BITS   = 2;
   localparam int CFG_BITS  = 5;
   localparam int FREE_BITS = 5;

   // parameter defaults for the top level
   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int DEF_TAG_BITS     = 6;
   localparam int DEF_PAYLOAD_BITS = 32;

   // capacity register value after reset
   localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

   // operation codes
   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_WAKEUP = 2'd1,
      OP_SELECT = 2'd2,
      OP_REMOVE = 2'd3
   } iqws_op_type;

   // per-entry source flags
   typedef struct packed {
      logic s2_ready;
      logic s2_renamed;
      logic s1_ready;
      logic s1_renamed;
   } iqws_flags_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic insert;
      logic wakeup;
      logic close_gap;
      logic advance;
      logic restart;
   } iqws_ctrl_type;

endpackage

// ===== rtl/issue_queue_wakeup_select.sv =====
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  op, tags, source flags, payload
// rsp       out        rsp_valid/rsp_stall  accepted, ready_found, tag, payload, free
// csr       in         csr_valid/csr_ready  capacity (5 bits)
//
// a transaction is held in a command register; insert and wakeup finish there once the result register is free
// select and remove walk a probe down the cell row, one cell a cycle, until it hits
// a matching cell or reaches the first empty cell (a miss)
// the next transaction is accepted in the cycle its predecessor finishes
// synchronous reset empties the queue and sets the capacity to 16
// rsp_stall holds the result register and keeps the command from finishing; a new transaction enters only then if empty
module issue_queue_wakeup_select #(
   parameter int QUEUE_DEPTH  = iqws_pkg::DEF_QUEUE_DEPTH,
   parameter int TAG_BITS     = iqws_pkg::DEF_TAG_BITS,
   parameter int PAYLOAD_BITS = iqws_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [iqws_pkg::OP_BITS-1:0]  req_op,
   input  logic [TAG_BITS-1:0]           req_in_tag,
   input  logic [TAG_BITS-1:0]           req_src1_tag,
   input  logic                          req_src1_renamed,
   input  logic                          req_src1_ready,
   input  logic [TAG_BITS-1:0]           req_src2_tag,
   input  logic                          req_src2_renamed,
   input  logic                          req_src2_ready,
   input  logic [PAYLOAD_BITS-1:0]       req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic                          rsp_ready_found,
   output logic [TAG_BITS-1:0]           rsp_out_tag,
   output logic [PAYLOAD_BITS-1:0]       rsp_out_payload,
   output logic [iqws_pkg::FREE_BITS-1:0] rsp_free_entries,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [iqws_pkg::CFG_BITS-1:0] csr_wdata
);
   import iqws_pkg::*;

   localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_BITS = (OCC_BITS > CFG_BITS) ? OCC_BITS : CFG_BITS;

   // command register
   logic                    cmd_valid_ff, cmd_valid_in;
   iqws_op_type             cmd_op_ff;
   logic [TAG_BITS-1:0]     cmd_tag_ff, cmd_src1_ff, cmd_src2_ff;
   iqws_flags_type          cmd_flags_ff;
   logic [PAYLOAD_BITS-1:0] cmd_payload_ff;

   // queue bookkeeping
   logic [CFG_BITS-1:0]     cap_ff;
   logic [OCC_BITS-1:0]     occ_ff, occ_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_accepted_ff, rsp_found_ff;
   logic [TAG_BITS-1:0]     rsp_tag_ff;
   logic [PAYLOAD_BITS-1:0] rsp_payload_ff;
   logic [FREE_BITS-1:0]    rsp_free_ff;

   // cell row, one extra empty position past the young end
   logic [QUEUE_DEPTH:0]    valid_vec;
   logic [QUEUE_DEPTH-1:0]  ahead_vec, at_vec, sel_vec, rmv_vec;
   logic [TAG_BITS-1:0]     cell_tag  [QUEUE_DEPTH+1];
   logic [TAG_BITS-1:0]     cell_src1 [QUEUE_DEPTH+1];
   logic [TAG_BITS-1:0]     cell_src2 [QUEUE_DEPTH+1];
   iqws_flags_type          cell_flags [QUEUE_DEPTH+1];
   logic [PAYLOAD_BITS-1:0] cell_pay  [QUEUE_DEPTH+1];

   iqws_ctrl_type           ctrl;
   logic                    req_take, out_free, is_scan, hit, miss, resolve, finish, room;
   logic [TAG_BITS-1:0]     probe_tag;
   logic [PAYLOAD_BITS-1:0] probe_pay;
   logic [CMP_BITS-1:0]     limit_w, occ_w, occ_next_w, free_w;

   // handshakes
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = cmd_valid_ff & ~finish;
   assign req_take  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // capacity check
   assign occ_w   = CMP_BITS'(occ_ff);
   assign limit_w = (CMP_BITS'(cap_ff) < CMP_BITS'(QUEUE_DEPTH)) ? CMP_BITS'(cap_ff)
                                                                 : CMP_BITS'(QUEUE_DEPTH);
   assign room    = occ_w < limit_w;

   // probe outcome
   assign is_scan = (cmd_op_ff == OP_SELECT) || (cmd_op_ff == OP_REMOVE);
   assign hit     = (cmd_op_ff == OP_SELECT) ? |sel_vec : |rmv_vec;
   assign miss    = ~(|at_vec) | (|(at_vec & ~valid_vec[QUEUE_DEPTH-1:0]));
   assign resolve = is_scan ? (hit | miss) : 1'b1;
   assign finish  = cmd_valid_ff & resolve & out_free;

   // broadcast control
   always_comb begin
      ctrl.insert    = finish & (cmd_op_ff == OP_INSERT) & room;
      ctrl.wakeup    = finish & (cmd_op_ff == OP_WAKEUP);
      ctrl.close_gap = finish & (cmd_op_ff == OP_REMOVE) & hit;
      ctrl.advance   = cmd_valid_ff & is_scan & ~resolve;
      ctrl.restart   = finish;
   end

   // entry under the probe
   always_comb begin
      probe_tag = '0;
      probe_pay = '0;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (at_vec[k]) begin
            probe_tag = probe_tag | cell_tag[k];
            probe_pay = probe_pay | cell_pay[k];
         end
      end
   end

   // occupancy and free count after the operation
   always_comb begin
      occ_in = occ_ff;
      if (ctrl.insert) begin
         occ_in = occ_ff + OCC_BITS'(1);
      end else if (ctrl.close_gap) begin
         occ_in = occ_ff - OCC_BITS'(1);
      end
   end
   assign occ_next_w = CMP_BITS'(occ_in);
   assign free_w     = (limit_w > occ_next_w) ? (limit_w - occ_next_w) : '0;

   assign cmd_valid_in = req_take | (cmd_valid_ff & ~finish);
   assign rsp_valid_in = finish | (rsp_valid_ff & rsp_stall);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // command capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_op_ff               <= iqws_op_type'(req_op);
         cmd_tag_ff              <= req_in_tag;
         cmd_src1_ff             <= req_src1_tag;
         cmd_src2_ff             <= req_src2_tag;
         cmd_flags_ff.s1_renamed <= req_src1_renamed;
         cmd_flags_ff.s1_ready   <= req_src1_ready;
         cmd_flags_ff.s2_renamed <= req_src2_renamed;
         cmd_flags_ff.s2_ready   <= req_src2_ready;
         cmd_payload_ff          <= req_payload;
      end
   end

   // result capture
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_accepted_ff <= ctrl.insert | ctrl.close_gap;
         rsp_found_ff    <= (cmd_op_ff == OP_SELECT) & hit;
         rsp_tag_ff      <= (is_scan && hit) ? probe_tag : '0;
         rsp_payload_ff  <= (is_scan && hit) ? probe_pay : '0;
         rsp_free_ff     <= free_w[FREE_BITS-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_ready_found  = rsp_found_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_payload  = rsp_payload_ff;
   assign rsp_free_entries = rsp_free_ff;

   // empty position past the young end
   assign valid_vec[QUEUE_DEPTH]  = 1'b0;
   assign cell_tag[QUEUE_DEPTH]   = '0;
   assign cell_src1[QUEUE_DEPTH]  = '0;
   assign cell_src2[QUEUE_DEPTH]  = '0;
   assign cell_flags[QUEUE_DEPTH] = '0;
   assign cell_pay[QUEUE_DEPTH]   = '0;

   // cell row, oldest entry in cell 0
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      logic prev_valid, prev_ahead;
      if (k == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign prev_ahead = 1'b0;
      end else begin : g_body
         assign prev_valid = valid_vec[k-1];
         assign prev_ahead = ahead_vec[k-1];
      end
      iqws_cell #(
         .TAG_BITS     (TAG_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .key_tag      (cmd_tag_ff),
         .ins_src1     (cmd_src1_ff),
         .ins_src2     (cmd_src2_ff),
         .ins_flags    (cmd_flags_ff),
         .ins_payload  (cmd_payload_ff),
         .prev_valid   (prev_valid),
         .prev_ahead   (prev_ahead),
         .next_valid   (valid_vec[k+1]),
         .next_tag     (cell_tag[k+1]),
         .next_src1    (cell_src1[k+1]),
         .next_src2    (cell_src2[k+1]),
         .next_flags   (cell_flags[k+1]),
         .next_payload (cell_pay[k+1]),
         .valid        (valid_vec[k]),
         .ahead        (ahead_vec[k]),
         .at_probe     (at_vec[k]),
         .sel_hit      (sel_vec[k]),
         .rmv_hit      (rmv_vec[k]),
         .tag          (cell_tag[k]),
         .src1         (cell_src1[k]),
         .src2         (cell_src2[k]),
         .flags        (cell_flags[k]),
         .payload      (cell_pay[k])
      );
   end

   // checks
   a_probe_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(at_vec))
      else $error("probe on more than one cell");

   a_packed_row: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec[QUEUE_DEPTH-1:0]) == int'(occ_ff))
      else $error("valid cells disagree with occupancy");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_BITS'(occ_ff) <= CMP_BITS'(QUEUE_DEPTH))
      else $error("occupancy beyond depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> occ_ff == $past(occ_ff) + OCC_BITS'(1))
      else $error("insert did not grow occupancy");

   a_remove_hit_only: assert property (@(posedge clock) disable iff (reset)
      ctrl.close_gap |-> (|rmv_vec) && (cmd_op_ff == OP_REMOVE))
      else $error("gap closed without a tag hit");

endmodule

// ===== rtl/iqws_cell.sv =====
module iqws_cell #(
   parameter int TAG_BITS     = iqws_pkg::DEF_TAG_BITS,
   parameter int PAYLOAD_BITS = iqws_pkg::DEF_PAYLOAD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  iqws_pkg::iqws_ctrl_type  ctrl,
   input  logic [TAG_BITS-1:0]      key_tag,
   input  logic [TAG_BITS-1:0]      ins_src1,
   input  logic [TAG_BITS-1:0]      ins_src2,
   input  iqws_pkg::iqws_flags_type ins_flags,
   input  logic [PAYLOAD_BITS-1:0]  ins_payload,
   input  logic                     prev_valid,
   input  logic                     prev_ahead,
   input  logic                     next_valid,
   input  logic [TAG_BITS-1:0]      next_tag,
   input  logic [TAG_BITS-1:0]      next_src1,
   input  logic [TAG_BITS-1:0]      next_src2,
   input  iqws_pkg::iqws_flags_type next_flags,
   input  logic [PAYLOAD_BITS-1:0]  next_payload,
   output logic                     valid,
   output logic                     ahead,
   output logic                     at_probe,
   output logic                     sel_hit,
   output logic                     rmv_hit,
   output logic [TAG_BITS-1:0]      tag,
   output logic [TAG_BITS-1:0]      src1,
   output logic [TAG_BITS-1:0]      src2,
   output iqws_pkg::iqws_flags_type flags,
   output logic [PAYLOAD_BITS-1:0]  payload
);
   import iqws_pkg::*;

   logic                    valid_ff, valid_in;
   logic                    ahead_ff, ahead_in;
   logic [TAG_BITS-1:0]     tag_ff, tag_in;
   logic [TAG_BITS-1:0]     src1_ff, src1_in;
   logic [TAG_BITS-1:0]     src2_ff, src2_in;
   iqws_flags_type          flags_ff, flags_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic                    is_tail;

   // probe sits on the first cell still ahead of it
   assign at_probe = ahead_ff & ~prev_ahead;
   assign sel_hit  = at_probe & valid_ff & flags_ff.s1_ready & flags_ff.s2_ready;
   assign rmv_hit  = at_probe & valid_ff & (tag_ff == key_tag);
   assign is_tail  = ~valid_ff & prev_valid;

   // probe walk
   always_comb begin
      ahead_in = ahead_ff;
      if (ctrl.restart) begin
         ahead_in = 1'b1;
      end else if (ctrl.advance) begin
         ahead_in = ahead_ff & prev_ahead;
      end
   end

   // entry update: close gap, append at tail, or wakeup
   always_comb begin
      valid_in   = valid_ff;
      tag_in     = tag_ff;
      src1_in    = src1_ff;
      src2_in    = src2_ff;
      flags_in   = flags_ff;
      payload_in = payload_ff;
      if (ctrl.close_gap && ahead_ff) begin
         valid_in   = next_valid;
         tag_in     = next_tag;
         src1_in    = next_src1;
         src2_in    = next_src2;
         flags_in   = next_flags;
         payload_in = next_payload;
      end else if (ctrl.insert && is_tail) begin
         valid_in   = 1'b1;
         tag_in     = key_tag;
         src1_in    = ins_src1;
         src2_in    = ins_src2;
         flags_in   = ins_flags;
         payload_in = ins_payload;
      end else if (ctrl.wakeup && valid_ff) begin
         if (flags_ff.s1_renamed && (src1_ff == key_tag)) begin
            flags_in.s1_ready = 1'b1;
         end
         if (flags_ff.s2_renamed && (src2_ff == key_tag)) begin
            flags_in.s2_ready = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ahead_ff <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         ahead_ff <= ahead_in;
      end
   end

   // entry contents
   always_ff @(posedge clock) begin
      tag_ff     <= tag_in;
      src1_ff    <= src1_in;
      src2_ff    <= src2_in;
      flags_ff   <= flags_in;
      payload_ff <= payload_in;
   end

   assign valid   = valid_ff;
   assign ahead   = ahead_ff;
   assign tag     = tag_ff;
   assign src1    = src1_ff;
   assign src2    = src2_ff;
   assign flags   = flags_ff;
   assign payload = payload_ff;

endmodule
